// File: sv/slfr_pkg.sv
// slfr_pkg: shared types and constants of the sync/length frame receiver
// no dependencies; used by every module of the block by scoped names

package slfr_pkg;

   // sync bytes that open a frame
   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'hBB;

   // configuration register indexes
   localparam logic [2:0] CSR_SAY_HI_CODE   = 3'd0;
   localparam logic [2:0] CSR_TURN_CODE     = 3'd1;
   localparam logic [2:0] CSR_RUN_CODE      = 3'd2;
   localparam logic [2:0] CSR_BODY_LIMIT    = 3'd3;
   localparam logic [2:0] CSR_TIMEOUT_LIMIT = 3'd4;

   // configuration reset values
   localparam logic [7:0] RST_SAY_HI_CODE   = 8'd1;
   localparam logic [7:0] RST_TURN_CODE     = 8'd2;
   localparam logic [7:0] RST_RUN_CODE      = 8'd3;
   localparam logic [7:0] RST_BODY_LIMIT    = 8'd64;
   localparam logic [7:0] RST_TIMEOUT_LIMIT = 8'd10;

   // framer phases
   typedef enum logic [2:0] {
      PH_HUNT0,
      PH_HUNT1,
      PH_LENGTH,
      PH_BODY,
      PH_CRC
   } phase_type;

   // decoded command kinds
   typedef enum logic [1:0] {
      KIND_SAY_HI  = 2'd0,
      KIND_TURN    = 2'd1,
      KIND_RUN     = 2'd2,
      KIND_UNKNOWN = 2'd3
   } kind_type;

   // configuration register file contents
   typedef struct packed {
      logic [7:0] say_hi_code;
      logic [7:0] turn_code;
      logic [7:0] run_code;
      logic [7:0] body_limit;
      logic [7:0] timeout_limit;
   } cfg_type;

   // completed frame handed from framer to decoder
   typedef struct packed {
      logic [7:0] command;
      logic [7:0] argument;
   } frame_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: sv/slfr_front.sv
// slfr_front: framer state machine; hunts sync bytes, reads length, body and crc
// depends on slfr_pkg; pushes completed frames into slfr_queue

module slfr_front (
   input  logic                        clock,
   input  logic                        reset,
   input  slfr_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_mode,
   input  logic [7:0]                  req_rx_byte,
   input  slfr_pkg::queue_status_type  queue_status,
   output logic                        push,
   output slfr_pkg::frame_type         push_frame
);

   slfr_pkg::phase_type phase_ff, phase_in;
   logic [7:0] body_length_ff, body_length_in;
   logic [7:0] bytes_received_ff, bytes_received_in;
   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] command_store_ff, command_store_in;
   logic [7:0] argument_store_ff, argument_store_in;
   logic       accept;
   logic       is_byte;
   logic       is_tick;
   logic [7:0] tick_count_inc;
   logic [7:0] bytes_received_inc;

   // stall only when the queue cannot take a frame
   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign is_byte   = accept && !req_mode;
   assign is_tick   = accept && req_mode;

   assign tick_count_inc     = tick_count_ff + 8'd1;
   assign bytes_received_inc = bytes_received_ff + 8'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_tick) begin
         if (phase_ff == slfr_pkg::PH_BODY && tick_count_inc > cfg.timeout_limit) begin
            phase_in = slfr_pkg::PH_HUNT0;
         end
      end else if (is_byte) begin
         case (phase_ff)
            slfr_pkg::PH_HUNT0: begin
               if (req_rx_byte == slfr_pkg::SYNC_FIRST) begin
                  phase_in = slfr_pkg::PH_HUNT1;
               end
            end
            slfr_pkg::PH_HUNT1: begin
               phase_in = (req_rx_byte == slfr_pkg::SYNC_SECOND) ? slfr_pkg::PH_LENGTH
                                                                  : slfr_pkg::PH_HUNT0;
            end
            slfr_pkg::PH_LENGTH: begin
               if (req_rx_byte >= cfg.body_limit) begin
                  phase_in = slfr_pkg::PH_HUNT0;
               end else if (req_rx_byte == 8'd0) begin
                  phase_in = slfr_pkg::PH_CRC;
               end else begin
                  phase_in = slfr_pkg::PH_BODY;
               end
            end
            slfr_pkg::PH_BODY: begin
               if (bytes_received_inc >= body_length_ff) begin
                  phase_in = slfr_pkg::PH_CRC;
               end
            end
            slfr_pkg::PH_CRC: begin
               phase_in = slfr_pkg::PH_HUNT0;
            end
            default: begin
               phase_in = slfr_pkg::PH_HUNT0;
            end
         endcase
      end
   end

   // counters, stores and frame push
   always_comb begin
      body_length_in    = body_length_ff;
      bytes_received_in = bytes_received_ff;
      tick_count_in     = tick_count_ff;
      command_store_in  = command_store_ff;
      argument_store_in = argument_store_ff;
      push              = 1'b0;
      if (is_tick) begin
         if (phase_ff == slfr_pkg::PH_BODY) begin
            tick_count_in = tick_count_inc;
         end
      end else if (is_byte) begin
         case (phase_ff)
            slfr_pkg::PH_LENGTH: begin
               if (req_rx_byte < cfg.body_limit) begin
                  body_length_in    = req_rx_byte;
                  bytes_received_in = 8'd0;
                  tick_count_in     = 8'd0;
               end
            end
            slfr_pkg::PH_BODY: begin
               if (bytes_received_ff == 8'd0) begin
                  command_store_in = req_rx_byte;
               end else if (bytes_received_ff == 8'd1) begin
                  argument_store_in = req_rx_byte;
               end
               bytes_received_in = bytes_received_inc;
            end
            slfr_pkg::PH_CRC: begin
               push = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign push_frame.command  = command_store_ff;
   assign push_frame.argument = argument_store_ff;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= slfr_pkg::PH_HUNT0;
         body_length_ff    <= 8'd0;
         bytes_received_ff <= 8'd0;
         tick_count_ff     <= 8'd0;
         command_store_ff  <= 8'd0;
         argument_store_ff <= 8'd0;
      end else begin
         phase_ff          <= phase_in;
         body_length_ff    <= body_length_in;
         bytes_received_ff <= bytes_received_in;
         tick_count_ff     <= tick_count_in;
         command_store_ff  <= command_store_in;
         argument_store_ff <= argument_store_in;
      end
   end

endmodule

// File: sv/slfr_queue.sv
// slfr_queue: short frame queue between framer and decoder
// depends on slfr_pkg for the frame and status types

module slfr_queue #(
   parameter int Depth = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  slfr_pkg::frame_type         push_frame,
   input  logic                        pop,
   output slfr_pkg::frame_type         pop_frame,
   output slfr_pkg::queue_status_type  status
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   slfr_pkg::frame_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign status.full  = (count_ff == DepthCnt);
   assign status.empty = (count_ff == '0);
   assign pop_frame    = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_frame;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("frame pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("frame popped from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("queue fill count lost a push");
`endif

endmodule

// File: sv/slfr_back.sv
// slfr_back: command decoder and result output register
// depends on slfr_pkg; pops frames from slfr_queue

module slfr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  slfr_pkg::cfg_type           cfg,
   input  slfr_pkg::queue_status_type  queue_status,
   input  slfr_pkg::frame_type         pop_frame,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_command,
   output logic [1:0]                  rsp_kind,
   output logic signed [8:0]           rsp_argument
);

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               command_ff;
   slfr_pkg::kind_type       kind_ff, kind_in;
   logic signed [8:0]        argument_ff, argument_in;

   // load the output register when empty or being drained
   assign pop = !queue_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decode with say-hi taking priority over turn, then run
   always_comb begin
      if (pop_frame.command == cfg.say_hi_code) begin
         kind_in     = slfr_pkg::KIND_SAY_HI;
         argument_in = {1'b0, pop_frame.argument};
      end else if (pop_frame.command == cfg.turn_code) begin
         kind_in     = slfr_pkg::KIND_TURN;
         argument_in = {pop_frame.argument[7], pop_frame.argument};
      end else if (pop_frame.command == cfg.run_code) begin
         kind_in     = slfr_pkg::KIND_RUN;
         argument_in = {1'b0, pop_frame.argument};
      end else begin
         kind_in     = slfr_pkg::KIND_UNKNOWN;
         argument_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         command_ff  <= pop_frame.command;
         kind_ff     <= kind_in;
         argument_ff <= argument_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_command  = command_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_argument = argument_ff;

`ifndef SYNTHESIS
   a_unknown_zero_arg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff == slfr_pkg::KIND_UNKNOWN) |-> argument_ff == '0)
      else $error("unknown command carries nonzero argument");

   a_unsigned_arg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == slfr_pkg::KIND_SAY_HI || kind_ff == slfr_pkg::KIND_RUN))
      |-> !argument_ff[8])
      else $error("unsigned argument has sign bit set");
`endif

endmodule

// File: sv/sync_length_frame_receiver.sv
// sync_length_frame_receiver: top level with configuration registers
// depends on slfr_pkg, slfr_front, slfr_queue and slfr_back
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   req_mode, req_rx_byte
//   rsp_      out        rsp_valid/rsp_ready   rsp_command, rsp_kind, rsp_argument
//   csr_      in         csr_valid/csr_ready   csr_index, csr_data
//
// one transaction per cycle on the request side while req_ready is high; the
// framer state machine acts only on accepted bytes or ticks
// after the crc byte is taken the frame is written into the queue and then
// popped into the decoder output register, which drives rsp_valid
// req_ready drops only while the frame queue is full; csr_ready is always high
// synchronous reset returns the framer to the sync hunt and the configuration
// registers to their reset values

module sync_length_frame_receiver #(
   parameter int QueueDepth = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_command,
   output logic [1:0]        rsp_kind,
   output logic signed [8:0] rsp_argument,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data
);

   slfr_pkg::cfg_type          cfg_ff, cfg_in;
   slfr_pkg::queue_status_type queue_status;
   slfr_pkg::frame_type        push_frame;
   slfr_pkg::frame_type        pop_frame;
   logic                       push;
   logic                       pop;

   assign csr_ready = 1'b1;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            slfr_pkg::CSR_SAY_HI_CODE:   cfg_in.say_hi_code   = csr_data;
            slfr_pkg::CSR_TURN_CODE:     cfg_in.turn_code     = csr_data;
            slfr_pkg::CSR_RUN_CODE:      cfg_in.run_code      = csr_data;
            slfr_pkg::CSR_BODY_LIMIT:    cfg_in.body_limit    = csr_data;
            slfr_pkg::CSR_TIMEOUT_LIMIT: cfg_in.timeout_limit = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.say_hi_code   <= slfr_pkg::RST_SAY_HI_CODE;
         cfg_ff.turn_code     <= slfr_pkg::RST_TURN_CODE;
         cfg_ff.run_code      <= slfr_pkg::RST_RUN_CODE;
         cfg_ff.body_limit    <= slfr_pkg::RST_BODY_LIMIT;
         cfg_ff.timeout_limit <= slfr_pkg::RST_TIMEOUT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // framer
   slfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_mode     (req_mode),
      .req_rx_byte  (req_rx_byte),
      .queue_status (queue_status),
      .push         (push),
      .push_frame   (push_frame)
   );

   // frame queue
   slfr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .pop_frame  (pop_frame),
      .status     (queue_status)
   );

   // decoder and output register
   slfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .pop_frame    (pop_frame),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_command  (rsp_command),
      .rsp_kind     (rsp_kind),
      .rsp_argument (rsp_argument)
   );

endmodule
